>>> rtl/cmx_pkg.sv
// shared constants, types and helpers for the complex matrix transpose product
`default_nettype none
package cmx_pkg;

   localparam int MAX_ROWS_A = 64;
   localparam int MAX_COLS   = 64;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int DIM_W      = 7;
   localparam int VAL_W      = 16;
   localparam int MUL_W      = 2 * VAL_W;
   localparam int ACC_W      = 39;
   localparam int BROW_W     = 16;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   // register indexes, decoded from the word address
   localparam logic REG_ROWS_A = 1'b0;
   localparam logic REG_COLS   = 1'b1;

   // opcodes of an input item
   localparam logic OP_WRITE_A  = 1'b0;
   localparam logic OP_STREAM_B = 1'b1;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
   } cmx_cfg_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                    a_we;
      logic [ROW_W-1:0]        a_row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] wr_re;
      logic signed [VAL_W-1:0] wr_im;
      logic signed [VAL_W-1:0] b_re;
      logic signed [VAL_W-1:0] b_im;
      logic                    acc_en;
      logic [DIM_W-1:0]        acc_rows;
      logic                    finish;
      logic                    shift;
   } cmx_ctl_type;

   // clamp a dimension register into 1..limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] limit);
      logic [DIM_W-1:0] r;
      r = v;
      if (r == '0) r = DIM_W'(1);
      if (r > limit) r = limit;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/cmx_req_if.sv
// input channel: A element writes and streamed B elements
`default_nettype none
interface cmx_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   opcode;
   logic [cmx_pkg::ROW_W-1:0]              a_row;
   logic [cmx_pkg::COL_W-1:0]              col;
   logic signed [cmx_pkg::VAL_W-1:0]       value_re;
   logic signed [cmx_pkg::VAL_W-1:0]       value_im;

   modport source(output valid, opcode, a_row, col, value_re, value_im, input ready);
   modport sink(input valid, opcode, a_row, col, value_re, value_im, output ready);
endinterface
`default_nettype wire

>>> rtl/cmx_rsp_if.sv
// result channel: one product entry per transfer
`default_nettype none
interface cmx_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [cmx_pkg::BROW_W-1:0]             b_row;
   logic [cmx_pkg::ROW_W-1:0]              a_row_out;
   logic signed [cmx_pkg::ACC_W-1:0]       prod_re;
   logic signed [cmx_pkg::ACC_W-1:0]       prod_im;
   logic                                   last;

   modport source(output valid, b_row, a_row_out, prod_re, prod_im, last, input ready);
   modport sink(input valid, b_row, a_row_out, prod_re, prod_im, last, output ready);
endinterface
`default_nettype wire

>>> rtl/cmx_csr.sv
// configuration registers rows_a and cols behind the apb port
`default_nettype none
module cmx_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [cmx_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [cmx_pkg::CSR_DW-1:0]   pwdata,
   output logic      [cmx_pkg::CSR_DW-1:0]   prdata,
   output logic                              pready,
   output cmx_pkg::cmx_cfg_type              cfg
);
   import cmx_pkg::*;

   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic             wr_fire;
   logic             reg_sel;
   logic             unused_addr;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite && pready;
   assign reg_sel = paddr[2];

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_fire) begin
         unique case (reg_sel)
            REG_ROWS_A: rows_in = pwdata[DIM_W-1:0];
            REG_COLS:   cols_in = pwdata[DIM_W-1:0];
            default:    rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_W'(MAX_ROWS_A);
         cols_ff <= DIM_W'(64);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ROWS_A: prdata = CSR_DW'(rows_ff);
         REG_COLS:   prdata = CSR_DW'(cols_ff);
         default:    prdata = '0;
      endcase
   end

   // cols is limited by both the store depth and the reach of the col field
   assign cfg.rows = clamp_dim(rows_ff, DIM_W'(MAX_ROWS_A));
   assign cfg.cols = clamp_dim(cols_ff, (MAX_COLS > 64) ? DIM_W'(64) : DIM_W'(MAX_COLS));

   assign unused_addr = ^{paddr[1:0], pwdata[CSR_DW-1:DIM_W]};
endmodule
`default_nettype wire

>>> rtl/cmx_cell.sv
// one A row: its column store, a complex multiplier, the accumulator and a shift-out stage
`default_nettype none
module cmx_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [cmx_pkg::ROW_W-1:0]      cell_idx,
   input  wire cmx_pkg::cmx_ctl_type           ctl,
   input  wire logic signed [cmx_pkg::ACC_W-1:0] shift_in_re,
   input  wire logic signed [cmx_pkg::ACC_W-1:0] shift_in_im,
   output logic signed [cmx_pkg::ACC_W-1:0]    shift_out_re,
   output logic signed [cmx_pkg::ACC_W-1:0]    shift_out_im
);
   import cmx_pkg::*;

   logic [MUL_W-1:0]        mem [MAX_COLS];
   logic [MUL_W-1:0]        rd_ff;
   logic signed [VAL_W-1:0] a_re, a_im;
   logic signed [MUL_W-1:0] prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic signed [ACC_W-1:0] res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic signed [ACC_W-1:0] term_re, term_im, sum_re, sum_im;
   logic                    mac_en;

   // A store: written by row select, read at the column of every item
   always_ff @(posedge clock) begin
      if (ctl.a_we && (ctl.a_row == cell_idx)) begin
         mem[ctl.col] <= {ctl.wr_re, ctl.wr_im};
      end
      rd_ff <= mem[ctl.col];
   end

   assign a_re = signed'(rd_ff[MUL_W-1:VAL_W]);
   assign a_im = signed'(rd_ff[VAL_W-1:0]);

   always_ff @(posedge clock) begin
      prr_ff <= a_re * ctl.b_re;
      pii_ff <= a_im * ctl.b_im;
      pri_ff <= a_re * ctl.b_im;
      pir_ff <= a_im * ctl.b_re;
   end

   assign mac_en  = ctl.acc_en && ({1'b0, cell_idx} < ctl.acc_rows);
   assign term_re = ACC_W'(prr_ff) - ACC_W'(pii_ff);
   assign term_im = ACC_W'(pri_ff) + ACC_W'(pir_ff);
   assign sum_re  = acc_re_ff + term_re;
   assign sum_im  = acc_im_ff + term_im;

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      res_re_in = res_re_ff;
      res_im_in = res_im_ff;
      if (ctl.acc_en && ctl.finish) begin
         // row done: park the total in the shift stage and restart from zero
         res_re_in = mac_en ? sum_re : acc_re_ff;
         res_im_in = mac_en ? sum_im : acc_im_ff;
         acc_re_in = '0;
         acc_im_in = '0;
      end else begin
         if (mac_en) begin
            acc_re_in = sum_re;
            acc_im_in = sum_im;
         end
         if (ctl.shift) begin
            res_re_in = shift_in_re;
            res_im_in = shift_in_im;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
   end

   always_ff @(posedge clock) begin
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
   end

   assign shift_out_re = res_re_ff;
   assign shift_out_im = res_im_ff;
endmodule
`default_nettype wire

>>> rtl/complex_matrix_transpose_product.sv
// Complex product C = A * transpose(B) over a chain of 64 row cells.
// A row's results show on rsp once its last B element has passed the stage-1 and stage-2
// registers. One A write or B element per cycle while req is ready; the last element of a
// B row holds req off in both stages and while the cells shift rows_a totals out toward cell 0.
// Reset: synchronous, clears accumulators, row counter and control; rows_a and cols go to 64.
// The A store is not cleared and holds no defined value until written.
`default_nettype none
module complex_matrix_transpose_product (
   input  wire logic                        clock,
   input  wire logic                        reset,
   cmx_req_if.sink                          req,
   cmx_rsp_if.source                        rsp,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [cmx_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [cmx_pkg::CSR_DW-1:0]  pwdata,
   output logic      [cmx_pkg::CSR_DW-1:0]  prdata,
   output logic                             pready
);
   import cmx_pkg::*;

   cmx_cfg_type cfg;
   cmx_ctl_type ctl;

   logic req_fire, b_take, b_finish, rsp_fire, load;

   logic                    v1_ff, v1_in, fin1_ff, fin1_in;
   logic [DIM_W-1:0]        rows1_ff, rows1_in;
   logic signed [VAL_W-1:0] bre1_ff, bim1_ff, bre1_in, bim1_in;
   logic                    v2_ff, v2_in, fin2_ff, fin2_in;
   logic [DIM_W-1:0]        rows2_ff, rows2_in;

   logic                    drain_ff, drain_in;
   logic [ROW_W-1:0]        drain_idx_ff, drain_idx_in;
   logic [DIM_W-1:0]        drain_rows_ff, drain_rows_in;
   logic [BROW_W-1:0]       brow_out_ff, brow_out_in;
   logic [BROW_W-1:0]       brow_cnt_ff, brow_cnt_in;
   logic                    drain_last;

   logic signed [ACC_W-1:0] chain_re [MAX_ROWS_A+1];
   logic signed [ACC_W-1:0] chain_im [MAX_ROWS_A+1];

   cmx_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   // no new item while a finished row is in flight or its totals are shifting out
   assign req.ready = !drain_ff && !(v1_ff && fin1_ff) && !(v2_ff && fin2_ff);
   assign req_fire  = req.valid && req.ready;
   assign b_take    = req_fire && (req.opcode == OP_STREAM_B) && ({1'b0, req.col} < cfg.cols);
   assign b_finish  = ({1'b0, req.col} == (cfg.cols - DIM_W'(1)));
   assign load      = v2_ff && fin2_ff;
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign drain_last = ({1'b0, drain_idx_ff} == (drain_rows_ff - DIM_W'(1)));

   always_comb begin
      v1_in    = b_take;
      fin1_in  = b_take && b_finish;
      rows1_in = cfg.rows;
      bre1_in  = req.value_re;
      bim1_in  = req.value_im;
      v2_in    = v1_ff;
      fin2_in  = v1_ff && fin1_ff;
      rows2_in = rows1_ff;
   end

   always_comb begin
      drain_in      = drain_ff;
      drain_idx_in  = drain_idx_ff;
      drain_rows_in = drain_rows_ff;
      brow_out_in   = brow_out_ff;
      brow_cnt_in   = brow_cnt_ff;
      if (load) begin
         drain_in      = 1'b1;
         drain_idx_in  = '0;
         drain_rows_in = rows2_ff;
         brow_out_in   = brow_cnt_ff;
         brow_cnt_in   = brow_cnt_ff + BROW_W'(1);
      end else if (rsp_fire) begin
         if (drain_last) begin
            drain_in = 1'b0;
         end else begin
            drain_idx_in = drain_idx_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         fin1_ff     <= 1'b0;
         v2_ff       <= 1'b0;
         fin2_ff     <= 1'b0;
         drain_ff    <= 1'b0;
         brow_cnt_ff <= '0;
      end else begin
         v1_ff       <= v1_in;
         fin1_ff     <= fin1_in;
         v2_ff       <= v2_in;
         fin2_ff     <= fin2_in;
         drain_ff    <= drain_in;
         brow_cnt_ff <= brow_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rows1_ff      <= rows1_in;
      bre1_ff       <= bre1_in;
      bim1_ff       <= bim1_in;
      rows2_ff      <= rows2_in;
      drain_idx_ff  <= drain_idx_in;
      drain_rows_ff <= drain_rows_in;
      brow_out_ff   <= brow_out_in;
   end

   always_comb begin
      ctl.a_we     = req_fire && (req.opcode == OP_WRITE_A);
      ctl.a_row    = req.a_row;
      ctl.col      = req.col;
      ctl.wr_re    = req.value_re;
      ctl.wr_im    = req.value_im;
      ctl.b_re     = bre1_ff;
      ctl.b_im     = bim1_ff;
      ctl.acc_en   = v2_ff;
      ctl.acc_rows = rows2_ff;
      ctl.finish   = fin2_ff;
      ctl.shift    = rsp_fire;
   end

   assign chain_re[MAX_ROWS_A] = '0;
   assign chain_im[MAX_ROWS_A] = '0;

   for (genvar g = 0; g < MAX_ROWS_A; g++) begin : g_cell
      cmx_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (ROW_W'(g)),
         .ctl         (ctl),
         .shift_in_re (chain_re[g+1]),
         .shift_in_im (chain_im[g+1]),
         .shift_out_re(chain_re[g]),
         .shift_out_im(chain_im[g])
      );
   end

   assign rsp.valid     = drain_ff;
   assign rsp.b_row     = brow_out_ff;
   assign rsp.a_row_out = drain_idx_ff;
   assign rsp.prod_re   = chain_re[0];
   assign rsp.prod_im   = chain_im[0];
   assign rsp.last      = drain_last;
endmodule
`default_nettype wire

>>> rtl/cmx_checker.sv
// port-level checks on the result sequence, bound to the top level
`default_nettype none
module cmx_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [cmx_pkg::ROW_W-1:0]   rsp_a_row_out,
   input wire logic                        rsp_last
);
   import cmx_pkg::*;

   // a pending result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // input is held off while a row of results is being delivered
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while results pending");

   // a row of results starts at A row zero
   a_first_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_a_row_out == '0)
      else $error("result row does not start at A row zero");

   // results of one row follow without gaps and in A-row order
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_a_row_out == $past(rsp_a_row_out) + ROW_W'(1)))
      else $error("result row sequence broken");

   // the row ends with its last entry
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("results continue after last");
endmodule

bind complex_matrix_transpose_product cmx_checker u_cmx_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_a_row_out(rsp.a_row_out),
   .rsp_last     (rsp.last)
);
`default_nettype wire

>>> verif/tb_complex_matrix_transpose_product.sv
// testbench for the complex A times B-transpose product block, with a self-checking predictor
`timescale 1ns / 100ps
module tb_complex_matrix_transpose_product;
   import cmx_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE     = 8;
   localparam int ITEM_GOAL  = 110;
   localparam int CALM_SPAN  = 10;

   typedef struct packed {
      logic                    opcode;
      logic [ROW_W-1:0]        a_row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] re;
      logic signed [VAL_W-1:0] im;
   } element_type;

   typedef struct packed {
      logic [BROW_W-1:0]       b_row;
      logic [ROW_W-1:0]        a_row;
      logic signed [ACC_W-1:0] re;
      logic signed [ACC_W-1:0] im;
      logic                    last;
   } product_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   cmx_req_if req_bus ();
   cmx_rsp_if rsp_bus ();

   complex_matrix_transpose_product dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   element_type             pending_elements[$];
   product_type             pending_products[$];
   logic signed [VAL_W-1:0] a_re_copy [MAX_ROWS_A][MAX_COLS];
   logic signed [VAL_W-1:0] a_im_copy [MAX_ROWS_A][MAX_COLS];
   logic signed [ACC_W-1:0] acc_re_copy [MAX_ROWS_A];
   logic signed [ACC_W-1:0] acc_im_copy [MAX_ROWS_A];
   logic [BROW_W-1:0]       b_row_count;
   logic [DIM_W-1:0]        rows_reg;
   logic [DIM_W-1:0]        cols_reg;
   bit                      a_loaded [MAX_ROWS_A][MAX_COLS];
   bit                      sender_idling;
   bit                      receiver_idling;
   int gap_left, stall_left, idle_cycles;
   int errors, element_count, product_count, rows_done, reg_writes, stimulus_items;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // dimension register as the block uses it
   function automatic int eff_dim(input logic [DIM_W-1:0] v, input int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return '1;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // A store writes, B accumulation and row completion
   task automatic apply_element(input element_type e);
      int          nr, nc;
      longint      are, aim, bre, bim;
      product_type p;
      element_count++;
      if (e.opcode == OP_WRITE_A) begin
         a_re_copy[e.a_row][e.col] = e.re;
         a_im_copy[e.a_row][e.col] = e.im;
      end else begin
         nr = eff_dim(rows_reg, MAX_ROWS_A);
         nc = eff_dim(cols_reg, MAX_COLS);
         if (int'(e.col) < nc) begin
            bre = e.re;
            bim = e.im;
            for (int r = 0; r < nr; r++) begin
               are = a_re_copy[r][e.col];
               aim = a_im_copy[r][e.col];
               acc_re_copy[r] += ACC_W'(are * bre - aim * bim);
               acc_im_copy[r] += ACC_W'(are * bim + aim * bre);
            end
            if (int'(e.col) == nc - 1) begin
               for (int r = 0; r < nr; r++) begin
                  p.b_row = b_row_count;
                  p.a_row = ROW_W'(r);
                  p.re    = acc_re_copy[r];
                  p.im    = acc_im_copy[r];
                  p.last  = (r == nr - 1);
                  pending_products.push_back(p);
               end
               for (int r = 0; r < MAX_ROWS_A; r++) begin
                  acc_re_copy[r] = '0;
                  acc_im_copy[r] = '0;
               end
               b_row_count++;
               rows_done++;
            end
         end
      end
   endtask

   task automatic cmp_field(input string name, input logic signed [63:0] want,
                            input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      product_type want;
      element_type seen;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            product_count++;
            if (pending_products.size() == 0) begin
               $error("product for B row %0d, A row %0d with none expected",
                      rsp_bus.b_row, rsp_bus.a_row_out);
               errors++;
            end else begin
               want = pending_products.pop_front();
               cmp_field("b_row", 64'(want.b_row), 64'(rsp_bus.b_row));
               cmp_field("a_row_out", 64'(want.a_row), 64'(rsp_bus.a_row_out));
               cmp_field("prod_re", 64'(want.re), 64'(rsp_bus.prod_re));
               cmp_field("prod_im", 64'(want.im), 64'(rsp_bus.prod_im));
               cmp_field("last", 64'(want.last), 64'(rsp_bus.last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.opcode = req_bus.opcode;
            seen.a_row  = req_bus.a_row;
            seen.col    = req_bus.col;
            seen.re     = req_bus.value_re;
            seen.im     = req_bus.value_im;
            apply_element(seen);
         end
      end
   end

   always @(posedge clock) begin : driver
      element_type nxt;
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.opcode   <= OP_WRITE_A;
         req_bus.a_row    <= '0;
         req_bus.col      <= '0;
         req_bus.value_re <= '0;
         req_bus.value_im <= '0;
         gap_left = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (sender_idling && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 11);
            req_bus.valid <= 1'b0;
         end else if (pending_elements.size() != 0) begin
            nxt = pending_elements.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.opcode   <= nxt.opcode;
            req_bus.a_row    <= nxt.a_row;
            req_bus.col      <= nxt.col;
            req_bus.value_re <= nxt.re;
            req_bus.value_im <= nxt.im;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("complex_matrix_transpose_product: mismatch");
         $finish;
      end
   end

   task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
      logic [CSR_DW-1:0] data;
      data = $urandom;
      data[DIM_W-1:0] = val;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({idx, 2'b00});
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_ROWS_A) rows_reg = val;
      else cols_reg = val;
      reg_writes++;
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] rv, input logic [DIM_W-1:0] cv);
      write_reg(REG_ROWS_A, rv);
      write_reg(REG_COLS, cv);
      @(negedge clock);
   endtask

   task automatic queue_write(input int r, input int c, input logic signed [VAL_W-1:0] re,
                              input logic signed [VAL_W-1:0] im);
      element_type e;
      e.opcode = OP_WRITE_A;
      e.a_row  = ROW_W'(r);
      e.col    = COL_W'(c);
      e.re     = re;
      e.im     = im;
      pending_elements.push_back(e);
      a_loaded[r][c] = 1'b1;
      stimulus_items++;
   endtask

   // B element; the A column it reads is loaded first where still empty
   task automatic queue_stream(input int c, input logic signed [VAL_W-1:0] re,
                               input logic signed [VAL_W-1:0] im);
      element_type e;
      int          nr, nc;
      nr = eff_dim(rows_reg, MAX_ROWS_A);
      nc = eff_dim(cols_reg, MAX_COLS);
      if (c < nc) begin
         for (int r = 0; r < nr; r++)
            if (!a_loaded[r][c]) queue_write(r, c, pick_value(), pick_value());
      end
      e.opcode = OP_STREAM_B;
      e.a_row  = ROW_W'($urandom);
      e.col    = COL_W'(c);
      e.re     = re;
      e.im     = im;
      pending_elements.push_back(e);
      stimulus_items++;
   endtask

   task automatic wait_settled();
      @(negedge clock);
      while (pending_elements.size() != 0 || req_bus.valid || pending_products.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_phase(input bit calm, input int span);
      logic [DIM_W-1:0] rv, cv;
      int               nc, target, k;
      case ($urandom_range(0, 9))
         0: rv = '0;
         default: rv = DIM_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
         0: cv = '0;
         1: cv = DIM_W'($urandom_range(65, 127));
         2: cv = DIM_W'(MAX_COLS);
         default: cv = DIM_W'($urandom_range(1, 5));
      endcase
      // keep the A fill small when the inner dimension is wide
      if (eff_dim(cv, MAX_COLS) > 8 && eff_dim(rv, MAX_ROWS_A) > 2)
         rv = DIM_W'($urandom_range(1, 2));
      set_dims(rv, cv);
      sender_idling   = !calm && $urandom_range(0, 3) != 0;
      receiver_idling = !calm && $urandom_range(0, 3) != 0;
      nc = eff_dim(cv, MAX_COLS);
      target = stimulus_items + span;
      while (stimulus_items < target) begin
         k = $urandom_range(0, 3);
         for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 7))
               0: queue_write($urandom_range(0, 63), $urandom_range(0, 63), pick_value(),
                              pick_value());
               1: if (nc < MAX_COLS)
                     queue_stream($urandom_range(nc, 63), pick_value(), pick_value());
               default: ;
            endcase
            queue_stream($urandom_range(0, nc - 1), pick_value(), pick_value());
         end
         // now and then a row is left open and runs on into the next one
         if ($urandom_range(0, 9) != 0) queue_stream(nc - 1, pick_value(), pick_value());
      end
      wait_settled();
   endtask

   initial begin
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      for (int r = 0; r < MAX_ROWS_A; r++) begin
         acc_re_copy[r] = '0;
         acc_im_copy[r] = '0;
      end
      b_row_count     = '0;
      rows_reg        = DIM_W'(MAX_ROWS_A);
      cols_reg        = DIM_W'(MAX_COLS);
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      stimulus_items  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset dimensions: full height, rows touch only the last column
      for (int r = 0; r < MAX_ROWS_A; r++)
         queue_write(r, MAX_COLS - 1, pick_value(), pick_value());
      queue_stream(MAX_COLS - 1, 16'sh8000, 16'sh8000);
      queue_stream(MAX_COLS - 1, 16'sh7fff, '1);
      wait_settled();

      // one A row, inner dimension clamped from above, repeated and unordered columns
      set_dims('0, 7'd127);
      queue_write(0, 7, 16'sh8000, 16'sh8000);
      queue_stream(7, 16'sh8000, 16'sh7fff);
      queue_stream(7, 16'sh7fff, 16'sh8000);
      queue_stream(2, pick_value(), pick_value());
      queue_stream(MAX_COLS - 1, 16'sh7fff, 16'sh7fff);
      wait_settled();

      // both dimensions clamped from above and an A update between rows
      set_dims(7'd127, 7'd127);
      queue_stream(MAX_COLS - 1, 16'sh7fff, 16'sh7fff);
      queue_write(5, MAX_COLS - 1, 16'sh8000, 16'sh8000);
      queue_stream(MAX_COLS - 1, '1, '1);
      wait_settled();

      // inner dimension clamped from below, ignored columns
      set_dims(7'd2, '0);
      queue_stream(0, pick_value(), pick_value());
      queue_stream(1, pick_value(), pick_value());
      queue_stream(MAX_COLS - 1, pick_value(), pick_value());
      queue_write(1, 0, 16'sh8000, 16'sh7fff);
      queue_stream(0, 16'sh8000, 16'sh8000);
      wait_settled();

      // dimensions change in the middle of a B row
      set_dims(7'd3, 7'd4);
      queue_stream(1, pick_value(), pick_value());
      queue_stream(0, pick_value(), pick_value());
      wait_settled();
      write_reg(REG_COLS, 7'd2);
      @(negedge clock);
      queue_stream(1, pick_value(), pick_value());
      wait_settled();

      while (stimulus_items < ITEM_GOAL - CALM_SPAN)
         random_phase(1'b0, $urandom_range(8, 16));
      random_phase(1'b1, CALM_SPAN);

      $display("run covered %0d element transfers and %0d product entries over %0d B rows",
               element_count, product_count, rows_done);
      $display("%0d register writes incl. clamped extremes and a mid-row change",
               reg_writes);
      if (errors == 0)
         $display("complex_matrix_transpose_product: match");
      else
         $display("complex_matrix_transpose_product: mismatch");
      $finish;
   end

endmodule
